FILE: hdl/tpwm_pkg.sv
// shared types and register map of the timer with pwm outputs
package tpwm_pkg;

   // command codes of a request
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   // register map
   localparam logic [3:0] REG_CTRL    = 4'd0;
   localparam logic [3:0] REG_IRQ_EN  = 4'd1;
   localparam logic [3:0] REG_STATUS  = 4'd2;
   localparam logic [3:0] REG_MODE0   = 4'd3;
   localparam logic [3:0] REG_MODE1   = 4'd4;
   localparam logic [3:0] REG_OUT_EN  = 4'd5;
   localparam logic [3:0] REG_COUNT   = 4'd6;
   localparam logic [3:0] REG_PRESC   = 4'd7;
   localparam logic [3:0] REG_RELOAD  = 4'd8;
   localparam logic [3:0] REG_CMP0    = 4'd9;

   // control and mode bit positions
   localparam int unsigned CTRL_RUN_BIT = 0;
   localparam int unsigned CTRL_OPM_BIT = 3;
   localparam int unsigned PRELOAD_BIT  = 3;
   localparam logic [2:0]  MODE_PWM1    = 3'd6;

   localparam int unsigned MAX_CHANNELS = 4;
   localparam int unsigned DATA_WIDTH   = 32;

   typedef struct packed {
      cmd_type                 cmd;
      logic [3:0]              reg_index;
      logic [DATA_WIDTH-1:0]   write_data;
   } req_item_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0]   read_data;
      logic [MAX_CHANNELS-1:0] pwm_out;
      logic                    irq;
      logic                    update_pulse;
   } rsp_item_type;

endpackage

FILE: hdl/tpwm_if.sv
// valid/ready channel interfaces for requests and responses

interface tpwm_req_if;
   logic                             valid;
   logic                             ready;
   tpwm_pkg::cmd_type                cmd;
   logic [3:0]                       reg_index;
   logic [tpwm_pkg::DATA_WIDTH-1:0]  write_data;

   modport source (output valid, cmd, reg_index, write_data, input ready);
   modport sink (input valid, cmd, reg_index, write_data, output ready);
endinterface

interface tpwm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [tpwm_pkg::DATA_WIDTH-1:0]   read_data;
   logic [tpwm_pkg::MAX_CHANNELS-1:0] pwm_out;
   logic                              irq;
   logic                              update_pulse;

   modport source (output valid, read_data, pwm_out, irq, update_pulse, input ready);
   modport sink (input valid, read_data, pwm_out, irq, update_pulse, output ready);
endinterface

FILE: hdl/tpwm_pwm.sv
// pwm mode 1 output levels for all channels
module tpwm_pwm #(
   parameter int unsigned COUNTER_WIDTH = 32,
   parameter int unsigned CHANNELS      = 4
) (
   input  logic [15:0]                         modes [2],
   input  logic [15:0]                         out_enables,
   input  logic [COUNTER_WIDTH-1:0]            count,
   input  logic [COUNTER_WIDTH-1:0]            compare [CHANNELS],
   output logic [tpwm_pkg::MAX_CHANNELS-1:0]   levels
);

   // each channel: mode byte check, enable check, count below compare
   for (genvar c = 0; c < tpwm_pkg::MAX_CHANNELS; c++) begin : g_chan
      if (c < CHANNELS) begin : g_used
         logic [7:0] mode_byte;
         assign mode_byte = modes[c / 2][(c % 2) * 8 +: 8];
         assign levels[c] = (mode_byte[6:4] == tpwm_pkg::MODE_PWM1)
                            && out_enables[4 * c]
                            && (count < compare[c]);
      end else begin : g_unused
         assign levels[c] = 1'b0;
      end
   end

endmodule

FILE: hdl/tpwm_core.sv
// timer state registers and the per-request update logic
module tpwm_core #(
   parameter int unsigned COUNTER_WIDTH   = 32,
   parameter int unsigned PRESCALER_WIDTH = 16,
   parameter int unsigned CHANNELS        = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  tpwm_pkg::req_item_type  item,
   output tpwm_pkg::rsp_item_type  result
);

   localparam logic [COUNTER_WIDTH-1:0]   CNT_ONE = COUNTER_WIDTH'(1);
   localparam logic [PRESCALER_WIDTH-1:0] PSC_ONE = PRESCALER_WIDTH'(1);

   logic                       run_ff, run_in;
   logic                       opm_ff, opm_in;
   logic                       ien_ff, ien_in;
   logic                       flag_ff, flag_in;
   logic [15:0]                modes_ff [2];
   logic [15:0]                modes_in [2];
   logic [15:0]                oe_ff, oe_in;
   logic [COUNTER_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [PRESCALER_WIDTH-1:0] psc_val_ff, psc_val_in;
   logic [PRESCALER_WIDTH-1:0] psc_cnt_ff, psc_cnt_in;
   logic [COUNTER_WIDTH-1:0]   reload_ff, reload_in;
   logic [COUNTER_WIDTH-1:0]   cmp_wr_ff [CHANNELS];
   logic [COUNTER_WIDTH-1:0]   cmp_wr_in [CHANNELS];
   logic [COUNTER_WIDTH-1:0]   cmp_act_ff [CHANNELS];
   logic [COUNTER_WIDTH-1:0]   cmp_act_in [CHANNELS];
   logic [CHANNELS-1:0]        preload_en;
   logic [tpwm_pkg::DATA_WIDTH-1:0] rdata;
   logic                       pulse;
   logic [tpwm_pkg::MAX_CHANNELS-1:0] levels;

   // compare preload enable per channel from its mode byte
   for (genvar c = 0; c < CHANNELS; c++) begin : g_preload
      assign preload_en[c] = modes_ff[c / 2][(c % 2) * 8 + tpwm_pkg::PRELOAD_BIT];
   end

   // next state and read data for the current request
   always_comb begin
      run_in     = run_ff;
      opm_in     = opm_ff;
      ien_in     = ien_ff;
      flag_in    = flag_ff;
      modes_in   = modes_ff;
      oe_in      = oe_ff;
      cnt_in     = cnt_ff;
      psc_val_in = psc_val_ff;
      psc_cnt_in = psc_cnt_ff;
      reload_in  = reload_ff;
      cmp_wr_in  = cmp_wr_ff;
      cmp_act_in = cmp_act_ff;
      rdata      = '0;
      pulse      = 1'b0;
      case (item.cmd)
         tpwm_pkg::CMD_TICK: begin
            if (run_ff) begin
               if (psc_cnt_ff < psc_val_ff) begin
                  psc_cnt_in = psc_cnt_ff + PSC_ONE;
               end else begin
                  psc_cnt_in = '0;
                  if (cnt_ff >= reload_ff) begin
                     // update event: wrap, flag, load compares
                     cnt_in  = '0;
                     flag_in = 1'b1;
                     pulse   = 1'b1;
                     for (int ch = 0; ch < CHANNELS; ch++) begin
                        cmp_act_in[ch] = cmp_wr_ff[ch];
                     end
                     if (opm_ff) begin
                        run_in = 1'b0;
                     end
                  end else begin
                     cnt_in = cnt_ff + CNT_ONE;
                  end
               end
            end
         end
         tpwm_pkg::CMD_WRITE: begin
            case (item.reg_index)
               tpwm_pkg::REG_CTRL: begin
                  run_in = item.write_data[tpwm_pkg::CTRL_RUN_BIT];
                  opm_in = item.write_data[tpwm_pkg::CTRL_OPM_BIT];
               end
               tpwm_pkg::REG_IRQ_EN: ien_in = item.write_data[0];
               // status bits clear on zero
               tpwm_pkg::REG_STATUS: flag_in = flag_ff & item.write_data[0];
               tpwm_pkg::REG_MODE0:  modes_in[0] = item.write_data[15:0];
               tpwm_pkg::REG_MODE1:  modes_in[1] = item.write_data[15:0];
               tpwm_pkg::REG_OUT_EN: oe_in = item.write_data[15:0];
               tpwm_pkg::REG_COUNT:  cnt_in = item.write_data[COUNTER_WIDTH-1:0];
               tpwm_pkg::REG_PRESC:  psc_val_in = item.write_data[PRESCALER_WIDTH-1:0];
               tpwm_pkg::REG_RELOAD: reload_in = item.write_data[COUNTER_WIDTH-1:0];
               default: begin
                  // compare registers; active copy follows at once without preload
                  for (int ch = 0; ch < CHANNELS; ch++) begin
                     if (item.reg_index == tpwm_pkg::REG_CMP0 + 4'(ch)) begin
                        cmp_wr_in[ch] = item.write_data[COUNTER_WIDTH-1:0];
                        if (!preload_en[ch]) begin
                           cmp_act_in[ch] = item.write_data[COUNTER_WIDTH-1:0];
                        end
                     end
                  end
               end
            endcase
         end
         tpwm_pkg::CMD_READ: begin
            case (item.reg_index)
               tpwm_pkg::REG_CTRL: begin
                  rdata[tpwm_pkg::CTRL_RUN_BIT] = run_ff;
                  rdata[tpwm_pkg::CTRL_OPM_BIT] = opm_ff;
               end
               tpwm_pkg::REG_IRQ_EN: rdata[0] = ien_ff;
               tpwm_pkg::REG_STATUS: rdata[0] = flag_ff;
               tpwm_pkg::REG_MODE0:  rdata = 32'(modes_ff[0]);
               tpwm_pkg::REG_MODE1:  rdata = 32'(modes_ff[1]);
               tpwm_pkg::REG_OUT_EN: rdata = 32'(oe_ff);
               tpwm_pkg::REG_COUNT:  rdata = 32'(cnt_ff);
               tpwm_pkg::REG_PRESC:  rdata = 32'(psc_val_ff);
               tpwm_pkg::REG_RELOAD: rdata = 32'(reload_ff);
               default: begin
                  for (int ch = 0; ch < CHANNELS; ch++) begin
                     if (item.reg_index == tpwm_pkg::REG_CMP0 + 4'(ch)) begin
                        rdata = 32'(cmp_wr_ff[ch]);
                     end
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   // output levels follow the state after this request
   tpwm_pwm #(
      .COUNTER_WIDTH (COUNTER_WIDTH),
      .CHANNELS      (CHANNELS)
   ) u_pwm (
      .modes       (modes_in),
      .out_enables (oe_in),
      .count       (cnt_in),
      .compare     (cmp_act_in),
      .levels      (levels)
   );

   assign result.read_data    = rdata;
   assign result.pwm_out      = levels;
   assign result.irq          = flag_in & ien_in;
   assign result.update_pulse = pulse;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         opm_ff      <= 1'b0;
         ien_ff      <= 1'b0;
         flag_ff     <= 1'b0;
         modes_ff[0] <= '0;
         modes_ff[1] <= '0;
         oe_ff       <= '0;
         cnt_ff      <= '0;
         psc_val_ff  <= '0;
         psc_cnt_ff  <= '0;
         reload_ff   <= '1;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            cmp_wr_ff[ch]  <= '0;
            cmp_act_ff[ch] <= '0;
         end
      end else if (step) begin
         run_ff     <= run_in;
         opm_ff     <= opm_in;
         ien_ff     <= ien_in;
         flag_ff    <= flag_in;
         modes_ff   <= modes_in;
         oe_ff      <= oe_in;
         cnt_ff     <= cnt_in;
         psc_val_ff <= psc_val_in;
         psc_cnt_ff <= psc_cnt_in;
         reload_ff  <= reload_in;
         cmp_wr_ff  <= cmp_wr_in;
         cmp_act_ff <= cmp_act_in;
      end
   end

   // an update event leaves the counter at zero with the flag set
   a_update_wraps: assert property (@(posedge clock) disable iff (reset)
      step && result.update_pulse |=> (cnt_ff == '0) && flag_ff)
      else $error("update event did not wrap the counter");

   // only a tick of a running timer can cause an update event
   a_update_source: assert property (@(posedge clock) disable iff (reset)
      step && result.update_pulse |-> (item.cmd == tpwm_pkg::CMD_TICK) && run_ff)
      else $error("update event without a running tick");

   // a stopped timer does not count on a tick
   a_stopped_holds: assert property (@(posedge clock) disable iff (reset)
      step && (item.cmd == tpwm_pkg::CMD_TICK) && !run_ff
      |=> $stable(cnt_ff) && $stable(psc_cnt_ff))
      else $error("stopped timer counted");

   // reads leave the timer state alone
   a_read_no_effect: assert property (@(posedge clock) disable iff (reset)
      step && (item.cmd == tpwm_pkg::CMD_READ)
      |=> $stable(cnt_ff) && $stable(flag_ff) && $stable(run_ff))
      else $error("register read changed timer state");

endmodule

FILE: hdl/timer_pwm_peripheral_top.sv
// top level of the timer with pwm outputs: request and response registers
// Each request is a clock tick, a register write or a register read, and
// every request produces exactly one response in order. The block accepts
// one request per clock cycle while the request register can advance. A
// request passes through the request register and then the response
// register, with the whole timer update done combinationally between
// them. Back-pressure on the response channel stalls the request side
// only once both registers hold a pending item. Read data is the register
// value before the request; pwm_out, irq and update_pulse reflect the
// timer state after it.
module timer_pwm_peripheral_top #(
   parameter int unsigned COUNTER_WIDTH   = 32,
   parameter int unsigned PRESCALER_WIDTH = 16,
   parameter int unsigned CHANNELS        = 4
) (
   input  logic        clock,
   input  logic        reset,
   tpwm_req_if.sink    req_if,
   tpwm_rsp_if.source  rsp_if
);

   logic                   in_valid_ff;
   tpwm_pkg::req_item_type in_item_ff;
   logic                   out_valid_ff;
   tpwm_pkg::rsp_item_type out_item_ff;
   tpwm_pkg::rsp_item_type result;
   logic                   advance;

   // the request register moves on when the response register is free
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   tpwm_core #(
      .COUNTER_WIDTH   (COUNTER_WIDTH),
      .PRESCALER_WIDTH (PRESCALER_WIDTH),
      .CHANNELS        (CHANNELS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_if.valid && req_if.ready) begin
         in_item_ff.cmd        <= req_if.cmd;
         in_item_ff.reg_index  <= req_if.reg_index;
         in_item_ff.write_data <= req_if.write_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.read_data    = out_item_ff.read_data;
   assign rsp_if.pwm_out      = out_item_ff.pwm_out;
   assign rsp_if.irq          = out_item_ff.irq;
   assign rsp_if.update_pulse = out_item_ff.update_pulse;

endmodule
